FILE: rtl/nnfs_pkg.sv
// nnfs_pkg: shared types and constants for the nearest neighbor frame scaler
// no dependencies; used by every other file of the block except nnfs_frame_mem
package nnfs_pkg;

  localparam int unsigned OpW      = 1;
  localparam int unsigned IndexW   = 15;
  localparam int unsigned PixelW   = 16;
  localparam int unsigned SrcWidthW = 9;
  localparam int unsigned DispSizeW = 11;
  localparam int unsigned DispCntW = 10;
  localparam int unsigned StepW    = 24;
  localparam int unsigned FracW    = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  localparam logic [OpW-1:0] OpWrite = 1'b0;
  localparam logic [OpW-1:0] OpFetch = 1'b1;

  localparam logic [DispSizeW-1:0] MaxDisplay = 11'd1024;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SOURCE_WIDTH   = 3'd0,
    CFG_DISPLAY_WIDTH  = 3'd1,
    CFG_DISPLAY_HEIGHT = 3'd2,
    CFG_COLUMN_STEP    = 3'd3,
    CFG_ROW_STEP       = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [SrcWidthW-1:0] source_width;
    logic [DispSizeW-1:0] display_width;
    logic [DispSizeW-1:0] display_height;
    logic [StepW-1:0]     column_step;
    logic [StepW-1:0]     row_step;
  } cfg_t;

  typedef struct packed {
    logic row_end;
    logic frame_end;
  } flags_t;

endpackage

FILE: rtl/nnfs_req_if.sv
// nnfs_req_if: request channel carrying write and fetch items
// depends on nnfs_pkg for field widths
interface nnfs_req_if;
  logic                          valid;
  logic                          ready;
  logic [nnfs_pkg::OpW-1:0]      op;
  logic [nnfs_pkg::IndexW-1:0]   write_index;
  logic [nnfs_pkg::PixelW-1:0]   write_pixel;

  modport source(output valid, output op, output write_index, output write_pixel,
                 input ready);
  modport sink(input valid, input op, input write_index, input write_pixel,
               output ready);
endinterface

FILE: rtl/nnfs_rsp_if.sv
// nnfs_rsp_if: result channel carrying display pixels and end flags
// depends on nnfs_pkg for field widths
interface nnfs_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [nnfs_pkg::PixelW-1:0] display_pixel;
  logic                        row_end;
  logic                        frame_end;

  modport source(output valid, output display_pixel, output row_end, output frame_end,
                 input ready);
  modport sink(input valid, input display_pixel, input row_end, input frame_end,
               output ready);
endinterface

FILE: rtl/nnfs_cfg_regs.sv
// nnfs_cfg_regs: configuration register file with write port
// depends on nnfs_pkg for cfg_t and register indexes
module nnfs_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [nnfs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [nnfs_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output nnfs_pkg::cfg_t                 cfg_o
);

  nnfs_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        nnfs_pkg::CFG_SOURCE_WIDTH:
          cfg_d.source_width = cfg_wdata_i[nnfs_pkg::SrcWidthW-1:0];
        nnfs_pkg::CFG_DISPLAY_WIDTH:
          cfg_d.display_width = cfg_wdata_i[nnfs_pkg::DispSizeW-1:0];
        nnfs_pkg::CFG_DISPLAY_HEIGHT:
          cfg_d.display_height = cfg_wdata_i[nnfs_pkg::DispSizeW-1:0];
        nnfs_pkg::CFG_COLUMN_STEP:
          cfg_d.column_step = cfg_wdata_i[nnfs_pkg::StepW-1:0];
        nnfs_pkg::CFG_ROW_STEP:
          cfg_d.row_step = cfg_wdata_i[nnfs_pkg::StepW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source_width   <= 9'd160;
      cfg_q.display_width  <= 11'd160;
      cfg_q.display_height <= 11'd192;
      cfg_q.column_step    <= 24'd65536;
      cfg_q.row_step       <= 24'd65536;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/nnfs_addr_gen.sv
// nnfs_addr_gen: raster counters and 8.16 accumulators giving the source read address
// depends on nnfs_pkg for cfg_t and flags_t
module nnfs_addr_gen #(
  parameter int unsigned ADDR_W = 15
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fetch_i,
  input  nnfs_pkg::cfg_t     cfg_i,
  output logic [ADDR_W-1:0]  rd_addr_o,
  output nnfs_pkg::flags_t   flags_o
);

  localparam int unsigned CntW  = nnfs_pkg::DispCntW;
  localparam int unsigned StepW = nnfs_pkg::StepW;
  localparam int unsigned FracW = nnfs_pkg::FracW;
  localparam int unsigned SumW  = StepW + 1;
  localparam int unsigned WholeW = SumW - FracW;
  localparam int unsigned ProdW = WholeW + nnfs_pkg::SrcWidthW;

  logic [StepW-1:0]  col_acc_q, col_acc_d;
  logic [FracW-1:0]  row_frac_q, row_frac_d;
  logic [ADDR_W-1:0] row_base_q, row_base_d;
  logic [CntW-1:0]   disp_col_q, disp_col_d;
  logic [CntW-1:0]   disp_row_q, disp_row_d;

  logic [CntW-1:0]   last_col, last_row;
  logic [SumW-1:0]   frac_sum;
  logic [WholeW-1:0] whole;
  logic [ProdW-1:0]  base_step;
  logic              at_row_end, at_frame_end;

  function automatic logic [CntW-1:0] last_index(input logic [nnfs_pkg::DispSizeW-1:0] size);
    logic [nnfs_pkg::DispSizeW-1:0] dec;
    dec = size - 1'b1;
    if (size == '0) begin
      last_index = '0;
    end else if (size > nnfs_pkg::MaxDisplay) begin
      last_index = '1;
    end else begin
      last_index = dec[CntW-1:0];
    end
  endfunction

  assign last_col     = last_index(cfg_i.display_width);
  assign last_row     = last_index(cfg_i.display_height);
  assign at_row_end   = disp_col_q >= last_col;
  assign at_frame_end = at_row_end && (disp_row_q >= last_row);

  assign frac_sum  = {{(SumW-FracW){1'b0}}, row_frac_q} + {1'b0, cfg_i.row_step};
  assign whole     = frac_sum[SumW-1:FracW];
  assign base_step = whole * cfg_i.source_width;

  assign rd_addr_o = row_base_q + ADDR_W'(col_acc_q[StepW-1:FracW]);
  assign flags_o.row_end   = at_row_end;
  assign flags_o.frame_end = at_frame_end;

  always_comb begin
    col_acc_d  = col_acc_q;
    row_frac_d = row_frac_q;
    row_base_d = row_base_q;
    disp_col_d = disp_col_q;
    disp_row_d = disp_row_q;
    if (fetch_i) begin
      if (at_row_end) begin
        disp_col_d = '0;
        col_acc_d  = '0;
        if (at_frame_end) begin
          disp_row_d = '0;
          row_frac_d = '0;
          row_base_d = '0;
        end else begin
          disp_row_d = disp_row_q + 1'b1;
          row_frac_d = frac_sum[FracW-1:0];
          row_base_d = row_base_q + ADDR_W'(base_step);
        end
      end else begin
        disp_col_d = disp_col_q + 1'b1;
        col_acc_d  = col_acc_q + cfg_i.column_step;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_acc_q  <= '0;
      row_frac_q <= '0;
      row_base_q <= '0;
      disp_col_q <= '0;
      disp_row_q <= '0;
    end else begin
      col_acc_q  <= col_acc_d;
      row_frac_q <= row_frac_d;
      row_base_q <= row_base_d;
      disp_col_q <= disp_col_d;
      disp_row_q <= disp_row_d;
    end
  end

endmodule

FILE: rtl/nnfs_frame_mem.sv
// nnfs_frame_mem: source frame store, one write port and one registered read port
// standalone; sized by the top level parameters
module nnfs_frame_mem #(
  parameter int unsigned DEPTH  = 32768,
  parameter int unsigned ADDR_W = 15,
  parameter int unsigned DATA_W = 16
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/nearest_neighbour_frame_scaler.sv
// nearest_neighbour_frame_scaler: one request per cycle while results are not stalled; a fetch
// result is presented in the cycle after its request is accepted, a write produces no result
// the frame store read port registers the pixel, and that register is the result stage
// reset clears counters, accumulators and result valid and loads register defaults;
// the frame store is not cleared
// depends on nnfs_pkg, nnfs_req_if, nnfs_rsp_if, nnfs_cfg_regs, nnfs_addr_gen, nnfs_frame_mem
module nearest_neighbour_frame_scaler #(
  parameter int unsigned SOURCE_PIXELS = 32768,
  parameter int unsigned PIXEL_BITS    = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  nnfs_req_if.sink                      req_i,
  nnfs_rsp_if.source                    rsp_o,
  input  logic                          cfg_we_i,
  input  logic [nnfs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [nnfs_pkg::CfgDataW-1:0] cfg_wdata_i
);

  localparam int unsigned ADDR_W = $clog2(SOURCE_PIXELS);

  nnfs_pkg::cfg_t   cfg;
  nnfs_pkg::flags_t flags, flags_q;
  logic [ADDR_W-1:0]     rd_addr;
  logic [PIXEL_BITS-1:0] rd_data;
  logic                  accept, fetch, store;
  logic                  rsp_valid_q, rsp_valid_d;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept = req_i.valid && req_i.ready;
  assign fetch  = accept && (req_i.op == nnfs_pkg::OpFetch);
  assign store  = accept && (req_i.op == nnfs_pkg::OpWrite)
                  && (32'(req_i.write_index) < SOURCE_PIXELS);

  nnfs_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  nnfs_addr_gen #(
    .ADDR_W (ADDR_W)
  ) u_addr_gen (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fetch_i   (fetch),
    .cfg_i     (cfg),
    .rd_addr_o (rd_addr),
    .flags_o   (flags)
  );

  nnfs_frame_mem #(
    .DEPTH  (SOURCE_PIXELS),
    .ADDR_W (ADDR_W),
    .DATA_W (PIXEL_BITS)
  ) u_frame_mem (
    .clk_i   (clk_i),
    .we_i    (store),
    .waddr_i (ADDR_W'(req_i.write_index)),
    .wdata_i (PIXEL_BITS'(req_i.write_pixel)),
    .re_i    (fetch),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (req_i.ready) begin
      rsp_valid_d = fetch;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fetch) begin
      flags_q <= flags;
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.display_pixel = nnfs_pkg::PixelW'(rd_data);
  assign rsp_o.row_end       = flags_q.row_end;
  assign rsp_o.frame_end     = flags_q.frame_end;

endmodule

FILE: tb/sv/nearest_neighbour_frame_scaler_tb.sv
`timescale 1ns / 1ps
// nearest_neighbour_frame_scaler_tb: directed table then random phases of pixel writes and
// fetches, each fetch checked against a table value or an in-bench raster scaler with its own frame copy
// depends on nnfs_pkg, nnfs_req_if, nnfs_rsp_if and the nearest_neighbour_frame_scaler rtl
module nearest_neighbour_frame_scaler_tb;

  localparam int unsigned StoreDepth = 32768;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned RandomItems = 750;
  localparam int unsigned PhaseItems = 60;
  localparam int unsigned CalmPhase = 4;

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_FETCH,
    ROW_CONFIG
  } row_kind_e;

  typedef struct packed {
    logic [nnfs_pkg::PixelW-1:0] pixel;
    logic                        row_end;
    logic                        frame_end;
  } pixel_result_t;

  typedef struct packed {
    row_kind_e                   kind;
    logic [nnfs_pkg::IndexW-1:0] index;
    logic [nnfs_pkg::PixelW-1:0] pixel;
    logic                        typed;
    pixel_result_t               want;
    nnfs_pkg::cfg_t              cfg;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic                          cfg_we_i;
  logic [nnfs_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [nnfs_pkg::CfgDataW-1:0] cfg_wdata_i;

  nnfs_req_if req_ch ();
  nnfs_rsp_if rsp_ch ();

  nearest_neighbour_frame_scaler dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  logic [nnfs_pkg::PixelW-1:0]   frame_copy [StoreDepth];
  bit                            written [StoreDepth];
  nnfs_pkg::cfg_t                scaler_cfg = {9'd160, 11'd160, 11'd192, 24'h010000,
                                               24'h010000};
  logic [nnfs_pkg::StepW-1:0]    col_pos = '0;
  logic [nnfs_pkg::StepW:0]      row_frac_acc = '0;
  logic [nnfs_pkg::IndexW-1:0]   row_start = '0;
  logic [nnfs_pkg::DispCntW-1:0] out_col = '0;
  logic [nnfs_pkg::DispCntW-1:0] out_row = '0;

  pixel_result_t pending_pixels [$];
  stim_row_t     stim_table [$];
  int unsigned   mismatch_count = 0;
  int unsigned   quiet_cycles = 0;
  bit            calm = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [nnfs_pkg::IndexW-1:0] next_read_addr();
    return row_start +
           nnfs_pkg::IndexW'(col_pos[nnfs_pkg::StepW-1:nnfs_pkg::FracW]);
  endfunction

  function automatic logic [nnfs_pkg::DispCntW-1:0] last_index(
      logic [nnfs_pkg::DispSizeW-1:0] size);
    if (size == '0) return '0;
    if (size > nnfs_pkg::MaxDisplay) return nnfs_pkg::DispCntW'(nnfs_pkg::MaxDisplay - 1);
    return nnfs_pkg::DispCntW'(size - 1);
  endfunction

  function automatic pixel_result_t scale_next_pixel();
    pixel_result_t res;
    logic [nnfs_pkg::IndexW-1:0] addr;
    int unsigned whole;
    addr = next_read_addr();
    res.pixel = written[addr] ? frame_copy[addr] : '0;
    res.row_end = 1'b0;
    res.frame_end = 1'b0;
    if (out_col >= last_index(scaler_cfg.display_width)) begin
      res.row_end = 1'b1;
      out_col = '0;
      col_pos = '0;
      if (out_row >= last_index(scaler_cfg.display_height)) begin
        res.frame_end = 1'b1;
        out_row = '0;
        row_frac_acc = '0;
        row_start = '0;
      end else begin
        out_row = out_row + 1'b1;
        row_frac_acc = row_frac_acc + scaler_cfg.row_step;
        whole = row_frac_acc >> nnfs_pkg::FracW;
        row_start = row_start + nnfs_pkg::IndexW'(whole * scaler_cfg.source_width);
        row_frac_acc[nnfs_pkg::StepW:nnfs_pkg::FracW] = '0;
      end
    end else begin
      out_col = out_col + 1'b1;
      col_pos = col_pos + scaler_cfg.column_step;
    end
    return res;
  endfunction

  function automatic void report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", what);
  endfunction

  function automatic void table_write(int unsigned index, int unsigned pixel);
    stim_row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.index = nnfs_pkg::IndexW'(index);
    r.pixel = nnfs_pkg::PixelW'(pixel);
    stim_table.push_back(r);
  endfunction

  function automatic void table_fetch(bit typed, int unsigned pixel, bit row_end, bit frame_end);
    stim_row_t r;
    r = '0;
    r.kind = ROW_FETCH;
    r.typed = typed;
    r.want = {nnfs_pkg::PixelW'(pixel), row_end, frame_end};
    stim_table.push_back(r);
  endfunction

  function automatic void table_config(int unsigned sw, int unsigned dw, int unsigned dh,
                                       int unsigned cs, int unsigned rs);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CONFIG;
    r.cfg = {nnfs_pkg::SrcWidthW'(sw), nnfs_pkg::DispSizeW'(dw), nnfs_pkg::DispSizeW'(dh),
             nnfs_pkg::StepW'(cs), nnfs_pkg::StepW'(rs)};
    stim_table.push_back(r);
  endfunction

  function automatic logic [nnfs_pkg::DispSizeW-1:0] pick_size(int unsigned small_max);
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return nnfs_pkg::MaxDisplay;
      3: return nnfs_pkg::DispSizeW'($urandom_range(0, 2047));
      default: return nnfs_pkg::DispSizeW'($urandom_range(1, small_max));
    endcase
  endfunction

  function automatic logic [nnfs_pkg::StepW-1:0] pick_step();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return nnfs_pkg::StepW'($urandom_range(0, 24'hffffff));
      default: return nnfs_pkg::StepW'($urandom_range(0, 24'h030000));
    endcase
  endfunction

  task automatic send_request(logic [nnfs_pkg::OpW-1:0] op,
                              logic [nnfs_pkg::IndexW-1:0] index,
                              logic [nnfs_pkg::PixelW-1:0] pixel, bit typed,
                              pixel_result_t want);
    pixel_result_t got;
    if (!calm) begin
      while ($urandom_range(99) < 19) begin
        req_ch.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    req_ch.valid <= 1'b1;
    req_ch.op <= op;
    req_ch.write_index <= index;
    req_ch.write_pixel <= pixel;
    do @(posedge clk_i); while (!req_ch.ready);
    if (op == nnfs_pkg::OpWrite) begin
      frame_copy[index] = pixel;
      written[index] = 1'b1;
    end else begin
      got = scale_next_pixel();
      pending_pixels.push_back(typed ? want : got);
    end
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_regs(nnfs_pkg::cfg_t c);
    nnfs_pkg::cfg_idx_e idx;
    logic [nnfs_pkg::CfgDataW-1:0] data;
    wait_drained();
    idx = idx.first();
    repeat (idx.num()) begin
      case (idx)
        nnfs_pkg::CFG_SOURCE_WIDTH:   data = nnfs_pkg::CfgDataW'(c.source_width);
        nnfs_pkg::CFG_DISPLAY_WIDTH:  data = nnfs_pkg::CfgDataW'(c.display_width);
        nnfs_pkg::CFG_DISPLAY_HEIGHT: data = nnfs_pkg::CfgDataW'(c.display_height);
        nnfs_pkg::CFG_COLUMN_STEP:    data = nnfs_pkg::CfgDataW'(c.column_step);
        default:                      data = nnfs_pkg::CfgDataW'(c.row_step);
      endcase
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx;
      cfg_wdata_i <= data;
      @(posedge clk_i);
      idx = idx.next();
    end
    cfg_we_i <= 1'b0;
    scaler_cfg = c;
  endtask

  always @(posedge clk_i) begin
    rsp_ch.ready <= calm || ($urandom_range(99) >= 19);
  end

  always @(posedge clk_i) begin
    pixel_result_t want;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("result with no request pending, display_pixel %h",
                                  rsp_ch.display_pixel));
      end else begin
        want = pending_pixels.pop_front();
        if (rsp_ch.display_pixel !== want.pixel)
          report_mismatch($sformatf("display_pixel expected %h got %h",
                                    want.pixel, rsp_ch.display_pixel));
        if (rsp_ch.row_end !== want.row_end)
          report_mismatch($sformatf("row_end expected %b got %b",
                                    want.row_end, rsp_ch.row_end));
        if (rsp_ch.frame_end !== want.frame_end)
          report_mismatch($sformatf("frame_end expected %b got %b",
                                    want.frame_end, rsp_ch.frame_end));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("nearest_neighbour_frame_scaler regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    nnfs_pkg::cfg_t              c;
    pixel_result_t               none;
    logic [nnfs_pkg::IndexW-1:0] addr;
    int unsigned                 random_items;
    int unsigned                 phase;

    rst_ni = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.op = nnfs_pkg::OpWrite;
    req_ch.write_index = '0;
    req_ch.write_pixel = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    none = '0;

    // reset defaults, first two pixels of the frame
    table_write(0, 16'hffff);
    table_write(1, 16'h0000);
    table_write(15'h7fff, 16'h5a5a);
    table_fetch(1, 16'hffff, 0, 0);
    table_fetch(1, 16'h0000, 0, 0);
    // width lowered mid-row, zero sizes act as one, zero source width holds the row base
    table_write(2, 16'h1234);
    table_config(0, 0, 2, 24'hffffff, 24'hffffff);
    table_fetch(1, 16'h1234, 1, 0);
    table_fetch(1, 16'hffff, 1, 1);
    // fractional steps
    table_config(3, 2, 2, 24'h018000, 24'h018000);
    table_write(3, 16'h0f0f);
    table_write(4, 16'hf0f0);
    repeat (4) table_fetch(0, 0, 0, 0);
    // column accumulator wraps
    table_config(1, 3, 1, 24'hffffff, 0);
    table_write(8'hff, 16'h8001);
    repeat (3) table_fetch(0, 0, 0, 0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (stim_table[i]) begin
      case (stim_table[i].kind)
        ROW_WRITE:
          send_request(nnfs_pkg::OpWrite, stim_table[i].index, stim_table[i].pixel, 1'b0,
                       none);
        ROW_FETCH:
          send_request(nnfs_pkg::OpFetch, nnfs_pkg::IndexW'($urandom_range(0, 32767)),
                       nnfs_pkg::PixelW'($urandom_range(0, 65535)), stim_table[i].typed,
                       stim_table[i].want);
        ROW_CONFIG:
          program_regs(stim_table[i].cfg);
        default: ;
      endcase
    end

    random_items = 0;
    phase = 0;
    while (random_items < RandomItems) begin
      case ($urandom_range(5))
        0: c.source_width = '0;
        1: c.source_width = '1;
        2: c.source_width = nnfs_pkg::SrcWidthW'($urandom_range(0, 511));
        default: c.source_width = nnfs_pkg::SrcWidthW'($urandom_range(1, 24));
      endcase
      c.display_width = pick_size(8);
      c.display_height = pick_size(6);
      c.column_step = pick_step();
      c.row_step = pick_step();
      program_regs(c);
      calm = (phase == CalmPhase);
      repeat (PhaseItems) begin
        if ($urandom_range(99) < 70) begin
          // the next fetch may only read a pixel that was stored
          addr = next_read_addr();
          if (!written[addr]) begin
            send_request(nnfs_pkg::OpWrite, addr,
                         nnfs_pkg::PixelW'($urandom_range(0, 65535)), 1'b0, none);
            random_items++;
          end
          send_request(nnfs_pkg::OpFetch, nnfs_pkg::IndexW'($urandom_range(0, 32767)),
                       nnfs_pkg::PixelW'($urandom_range(0, 65535)), 1'b0, none);
        end else begin
          send_request(nnfs_pkg::OpWrite, nnfs_pkg::IndexW'($urandom_range(0, 32767)),
                       nnfs_pkg::PixelW'($urandom_range(0, 65535)), 1'b0, none);
        end
        random_items++;
      end
      phase++;
    end
    calm = 1'b0;

    wait_drained();
    if (mismatch_count == 0 && pending_pixels.size() == 0) begin
      $display("nearest_neighbour_frame_scaler regression: pass");
    end else begin
      $display("nearest_neighbour_frame_scaler regression: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/nnfs_pkg.sv
rtl/nnfs_req_if.sv
rtl/nnfs_rsp_if.sv
rtl/nnfs_cfg_regs.sv
rtl/nnfs_addr_gen.sv
rtl/nnfs_frame_mem.sv
rtl/nearest_neighbour_frame_scaler.sv
tb/sv/nearest_neighbour_frame_scaler_tb.sv
